### rtl/core/mtps_pkg.sv
package mtps_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int PEAK_FRAC   = 32 - SAMPLE_BITS;
  localparam int CH_W        = 2;
  localparam int INC_W       = 36;
  localparam int PH_W        = 18;
  localparam int ACC_W       = 40;
  localparam int N_W         = 19;
  localparam int Q_BITS      = 18;
  localparam int CNT_W       = 16;
  localparam int DAMP_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int STEP_W      = 5;

  localparam logic [CH_W-1:0]   CH_LAST  = CH_W'(CHANNELS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(Q_BITS - 1);
  localparam logic signed [PH_W-1:0] PH_ONE = {1'b0, {(PH_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE,
    REG_SPF,
    REG_FDAMP,
    REG_ADAMP,
    REG_INC0,
    REG_INC1,
    REG_INC2,
    REG_INC3
  } reg_idx_e;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_PRCR,
    MUL_PICI,
    MUL_PRCI,
    MUL_PICR,
    MUL_NRN,
    MUL_NIN,
    MUL_OUT,
    MUL_DAMPR,
    MUL_DAMPI,
    MUL_PEAK
  } mul_sel_e;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_SMP,
    ACT_PEAK,
    ACT_NLOAD,
    ACT_DIV,
    ACT_NSTORE,
    ACT_SLOAD,
    ACT_SSUB,
    ACT_NR,
    ACT_SADD,
    ACT_NI,
    ACT_ACCR,
    ACT_ACCI,
    ACT_CNT,
    ACT_OLOAD,
    ACT_OSTORE,
    ACT_EMIT,
    ACT_DRWR,
    ACT_DIWR,
    ACT_PDAMP
  } act_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PEAK,
    ST_PCHK,
    ST_NDIV,
    ST_NSTORE,
    ST_CHSEL,
    ST_ROT,
    ST_COUNT,
    ST_FCHK,
    ST_OSEL,
    ST_OMUL,
    ST_OLOAD,
    ST_ODIV,
    ST_OSTORE,
    ST_EMIT,
    ST_DAMP,
    ST_PMUL,
    ST_PDAMP
  } state_e;

  typedef struct packed {
    mul_sel_e        mul;
    act_e            act;
    logic [CH_W-1:0] ch;
    logic            im;
  } cmd_t;

  typedef struct packed {
    logic                enable;
    logic                peak_zero;
    logic                frame_end;
    logic                out_free;
    logic [CHANNELS-1:0] active;
  } sts_t;

endpackage

### rtl/core/mtps_ctrl.sv
module mtps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mtps_pkg::sts_t    sts_i,
  output mtps_pkg::cmd_t    cmd_o
);

  mtps_pkg::state_e                  state_q, state_d;
  logic [mtps_pkg::STEP_W-1:0]       cnt_q, cnt_d;
  logic [mtps_pkg::CH_W-1:0]         ch_q, ch_d;
  logic                              im_q, im_d;
  logic                              ch_last;

  assign ch_last = (ch_q == mtps_pkg::CH_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtps_pkg::ST_IDLE;
      cnt_q   <= '0;
      ch_q    <= '0;
      im_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ch_q    <= ch_d;
      im_q    <= im_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ch_d       = ch_q;
    im_d       = im_q;
    in_ready_o = 1'b0;
    cmd_o.mul  = mtps_pkg::MUL_NONE;
    cmd_o.act  = mtps_pkg::ACT_NONE;
    cmd_o.ch   = ch_q;
    cmd_o.im   = im_q;
    unique case (state_q)
      mtps_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        // A transaction taken while disabled is dropped without effect.
        if (in_valid_i && sts_i.enable) begin
          cmd_o.act = mtps_pkg::ACT_SMP;
          state_d   = mtps_pkg::ST_PEAK;
        end
      end
      mtps_pkg::ST_PEAK: begin
        cmd_o.act = mtps_pkg::ACT_PEAK;
        state_d   = mtps_pkg::ST_PCHK;
      end
      mtps_pkg::ST_PCHK: begin
        if (sts_i.peak_zero) begin
          state_d = mtps_pkg::ST_IDLE;
        end else begin
          cmd_o.act = mtps_pkg::ACT_NLOAD;
          cnt_d     = '0;
          state_d   = mtps_pkg::ST_NDIV;
        end
      end
      mtps_pkg::ST_NDIV: begin
        cmd_o.act = mtps_pkg::ACT_DIV;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == mtps_pkg::DIV_LAST) state_d = mtps_pkg::ST_NSTORE;
      end
      mtps_pkg::ST_NSTORE: begin
        cmd_o.act = mtps_pkg::ACT_NSTORE;
        ch_d      = '0;
        state_d   = mtps_pkg::ST_CHSEL;
      end
      mtps_pkg::ST_CHSEL: begin
        if (sts_i.active[ch_q]) begin
          cnt_d   = '0;
          state_d = mtps_pkg::ST_ROT;
        end else if (ch_last) begin
          state_d = mtps_pkg::ST_COUNT;
        end else begin
          ch_d = ch_q + 1'b1;
        end
      end
      mtps_pkg::ST_ROT: begin
        // Rotate the phasor, then accumulate phasor times normalized sample.
        unique case (cnt_q[2:0])
          3'd0: cmd_o.mul = mtps_pkg::MUL_PRCR;
          3'd1: begin
            cmd_o.mul = mtps_pkg::MUL_PICI;
            cmd_o.act = mtps_pkg::ACT_SLOAD;
          end
          3'd2: begin
            cmd_o.mul = mtps_pkg::MUL_PRCI;
            cmd_o.act = mtps_pkg::ACT_SSUB;
          end
          3'd3: begin
            cmd_o.mul = mtps_pkg::MUL_PICR;
            cmd_o.act = mtps_pkg::ACT_NR;
          end
          3'd4: cmd_o.act = mtps_pkg::ACT_SADD;
          3'd5: begin
            cmd_o.mul = mtps_pkg::MUL_NRN;
            cmd_o.act = mtps_pkg::ACT_NI;
          end
          3'd6: begin
            cmd_o.mul = mtps_pkg::MUL_NIN;
            cmd_o.act = mtps_pkg::ACT_ACCR;
          end
          3'd7: cmd_o.act = mtps_pkg::ACT_ACCI;
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[2:0] == 3'd7) begin
          if (ch_last) begin
            state_d = mtps_pkg::ST_COUNT;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = mtps_pkg::ST_CHSEL;
          end
        end
      end
      mtps_pkg::ST_COUNT: begin
        cmd_o.act = mtps_pkg::ACT_CNT;
        state_d   = mtps_pkg::ST_FCHK;
      end
      mtps_pkg::ST_FCHK: begin
        if (sts_i.frame_end) begin
          ch_d    = '0;
          state_d = mtps_pkg::ST_OSEL;
        end else begin
          state_d = mtps_pkg::ST_IDLE;
        end
      end
      mtps_pkg::ST_OSEL: begin
        if (sts_i.active[ch_q]) begin
          im_d    = 1'b0;
          state_d = mtps_pkg::ST_OMUL;
        end else if (ch_last) begin
          ch_d    = '0;
          cnt_d   = '0;
          state_d = mtps_pkg::ST_DAMP;
        end else begin
          ch_d = ch_q + 1'b1;
        end
      end
      mtps_pkg::ST_OMUL: begin
        cmd_o.mul = mtps_pkg::MUL_OUT;
        state_d   = mtps_pkg::ST_OLOAD;
      end
      mtps_pkg::ST_OLOAD: begin
        cmd_o.act = mtps_pkg::ACT_OLOAD;
        cnt_d     = '0;
        state_d   = mtps_pkg::ST_ODIV;
      end
      mtps_pkg::ST_ODIV: begin
        cmd_o.act = mtps_pkg::ACT_DIV;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == mtps_pkg::DIV_LAST) state_d = mtps_pkg::ST_OSTORE;
      end
      mtps_pkg::ST_OSTORE: begin
        cmd_o.act = mtps_pkg::ACT_OSTORE;
        if (!im_q) begin
          im_d    = 1'b1;
          state_d = mtps_pkg::ST_OMUL;
        end else begin
          state_d = mtps_pkg::ST_EMIT;
        end
      end
      mtps_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.act = mtps_pkg::ACT_EMIT;
          im_d      = 1'b0;
          if (ch_last) begin
            ch_d    = '0;
            cnt_d   = '0;
            state_d = mtps_pkg::ST_DAMP;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = mtps_pkg::ST_OSEL;
          end
        end
      end
      mtps_pkg::ST_DAMP: begin
        unique case (cnt_q[1:0])
          2'd0: begin
            cmd_o.mul = mtps_pkg::MUL_DAMPR;
            cnt_d     = cnt_q + 1'b1;
          end
          2'd1: begin
            cmd_o.mul = mtps_pkg::MUL_DAMPI;
            cmd_o.act = mtps_pkg::ACT_DRWR;
            cnt_d     = cnt_q + 1'b1;
          end
          2'd2: begin
            cmd_o.act = mtps_pkg::ACT_DIWR;
            cnt_d     = '0;
            if (ch_last) begin
              ch_d    = '0;
              state_d = mtps_pkg::ST_PMUL;
            end else begin
              ch_d = ch_q + 1'b1;
            end
          end
          default: cnt_d = '0;
        endcase
      end
      mtps_pkg::ST_PMUL: begin
        cmd_o.mul = mtps_pkg::MUL_PEAK;
        state_d   = mtps_pkg::ST_PDAMP;
      end
      mtps_pkg::ST_PDAMP: begin
        cmd_o.act = mtps_pkg::ACT_PDAMP;
        state_d   = mtps_pkg::ST_IDLE;
      end
      default: state_d = mtps_pkg::ST_IDLE;
    endcase
  end

  a_rot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mtps_pkg::ST_ROT |-> cnt_q[4:3] == 2'b00)
    else $error("rotation step counter out of range");

  a_emit_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.act == mtps_pkg::ACT_EMIT |-> sts_i.active[ch_q] && sts_i.out_free)
    else $error("result emitted for an inactive channel or into a full register");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.act == mtps_pkg::ACT_SMP |=> state_q == mtps_pkg::ST_PEAK)
    else $error("sample load did not start the peak update");

endmodule

### rtl/core/mtps_datapath.sv
module mtps_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [mtps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mtps_pkg::INC_W-1:0]          cfg_data_i,
  input  logic signed [mtps_pkg::SAMPLE_BITS-1:0] sample_i,
  input  mtps_pkg::cmd_t                      cmd_i,
  output mtps_pkg::sts_t                      sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mtps_pkg::CH_W-1:0]           channel_o,
  output logic signed [mtps_pkg::PH_W-1:0]    phase_real_o,
  output logic signed [mtps_pkg::PH_W-1:0]    phase_imag_o,
  output logic                                last_o
);

  localparam logic signed [mtps_pkg::PH_W-1:0]  PH_MAX  = {1'b0, {(mtps_pkg::PH_W-1){1'b1}}};
  localparam logic signed [mtps_pkg::PH_W-1:0]  PH_MIN  = {1'b1, {(mtps_pkg::PH_W-1){1'b0}}};
  localparam logic signed [mtps_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(mtps_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [mtps_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(mtps_pkg::ACC_W-1){1'b0}}};

  function automatic logic signed [23:0] round17(input logic signed [39:0] v);
    logic [39:0] mag;
    logic [39:0] m;
    mag = v[39] ? 40'(-v) : 40'(v);
    m   = (mag + 40'd65536) >> 17;
    round17 = v[39] ? -$signed({1'b0, m[22:0]}) : $signed({1'b0, m[22:0]});
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [23:0] v);
    if (v > PH_MAX)      sat18 = PH_MAX;
    else if (v < PH_MIN) sat18 = PH_MIN;
    else                 sat18 = v[17:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    if (v > ACC_MAX)      sat40 = ACC_MAX;
    else if (v < ACC_MIN) sat40 = ACC_MIN;
    else                  sat40 = v[39:0];
  endfunction

  function automatic logic [39:0] mag40(input logic signed [39:0] v);
    mag40 = v[39] ? 40'(-v) : 40'(v);
  endfunction

  function automatic logic signed [17:0] out_sat(input logic [17:0] q, input logic ovf,
                                                 input logic neg);
    if (neg) begin
      if (ovf || q > 18'd131072) out_sat = PH_MIN;
      else                       out_sat = $signed(18'(18'd0 - q));
    end else begin
      if (ovf || q > 18'd131071) out_sat = PH_MAX;
      else                       out_sat = $signed(q);
    end
  endfunction

  // Configuration and state.
  logic                                   enable_q;
  logic [mtps_pkg::CNT_W-1:0]             spf_q;
  logic [mtps_pkg::DAMP_W-1:0]            fdamp_q, adamp_q;
  logic [mtps_pkg::INC_W-1:0]             inc_q  [mtps_pkg::CHANNELS];
  logic signed [mtps_pkg::PH_W-1:0]       pr_q   [mtps_pkg::CHANNELS];
  logic signed [mtps_pkg::PH_W-1:0]       pi_q   [mtps_pkg::CHANNELS];
  logic signed [mtps_pkg::ACC_W-1:0]      accr_q [mtps_pkg::CHANNELS];
  logic signed [mtps_pkg::ACC_W-1:0]      acci_q [mtps_pkg::CHANNELS];
  logic [31:0]                            peak_q;
  logic [mtps_pkg::CNT_W-1:0]             cnt_q;
  logic                                   out_valid_q;

  // Working registers.
  logic signed [mtps_pkg::SAMPLE_BITS-1:0] smp_q;
  logic signed [mtps_pkg::N_W-1:0]        n_q;
  logic signed [39:0]                     s_q;
  logic signed [mtps_pkg::PH_W-1:0]       nr_q, ni_q;
  logic signed [60:0]                     p_q;
  logic [31:0]                            rem_q, dvs_q;
  logic [mtps_pkg::Q_BITS-1:0]            lo_q, quo_q;
  logic                                   ovf_q;
  logic signed [mtps_pkg::PH_W-1:0]       resr_q, resi_q;
  logic [mtps_pkg::CH_W-1:0]              chan_q;
  logic signed [mtps_pkg::PH_W-1:0]       outr_q, outi_q;
  logic                                   last_q;

  logic signed [mtps_pkg::SAMPLE_BITS:0]  smp_x;
  logic [mtps_pkg::SAMPLE_BITS:0]         smag;
  logic [32:0]                            a_pk;
  logic [mtps_pkg::CNT_W-1:0]             spf_eff;
  logic [16:0]                            gain;
  logic signed [40:0]                     a_m;
  logic signed [19:0]                     b_m;
  logic signed [60:0]                     p_d;
  logic [32:0]                            rem2;
  logic                                   ge;
  logic [55:0]                            ysum;
  logic [39:0]                            y;
  logic [mtps_pkg::CHANNELS-1:0]          active;
  logic [mtps_pkg::CHANNELS-1:0]          low_mask;
  logic signed [mtps_pkg::PH_W-1:0]       s_rs;
  logic signed [23:0]                     p_rs;
  logic signed [mtps_pkg::ACC_W-1:0]      acc_sel;
  logic signed [mtps_pkg::ACC_W-1:0]      damp_pos;
  logic signed [mtps_pkg::PH_W-1:0]       cr, ci;

  assign smp_x   = smp_q;
  assign smag    = smp_x[mtps_pkg::SAMPLE_BITS] ? -smp_x : smp_x;
  assign a_pk    = {smag, {mtps_pkg::PEAK_FRAC{1'b0}}};
  assign spf_eff = (spf_q == '0) ? 16'd1 : spf_q;
  assign gain    = 17'd65536 - {1'b0, fdamp_q};
  assign cr      = $signed(inc_q[cmd_i.ch][35:18]);
  assign ci      = $signed(inc_q[cmd_i.ch][17:0]);
  assign acc_sel = cmd_i.im ? acci_q[cmd_i.ch] : accr_q[cmd_i.ch];
  assign s_rs    = sat18(round17(s_q));
  assign p_rs    = round17(p_q[39:0]);
  assign damp_pos = $signed({1'b0, p_q[54:16]});

  always_comb begin
    for (int i = 0; i < mtps_pkg::CHANNELS; i++) active[i] = (inc_q[i] != '0);
  end

  // One shared multiplier; its product is registered before any use.
  always_comb begin
    a_m = '0;
    b_m = '0;
    unique case (cmd_i.mul)
      mtps_pkg::MUL_NONE: begin
        a_m = '0;
        b_m = '0;
      end
      mtps_pkg::MUL_PRCR: begin
        a_m = 41'(pr_q[cmd_i.ch]);
        b_m = 20'(cr);
      end
      mtps_pkg::MUL_PICI: begin
        a_m = 41'(pi_q[cmd_i.ch]);
        b_m = 20'(ci);
      end
      mtps_pkg::MUL_PRCI: begin
        a_m = 41'(pr_q[cmd_i.ch]);
        b_m = 20'(ci);
      end
      mtps_pkg::MUL_PICR: begin
        a_m = 41'(pi_q[cmd_i.ch]);
        b_m = 20'(cr);
      end
      mtps_pkg::MUL_NRN: begin
        a_m = 41'(nr_q);
        b_m = 20'(n_q);
      end
      mtps_pkg::MUL_NIN: begin
        a_m = 41'(ni_q);
        b_m = 20'(n_q);
      end
      mtps_pkg::MUL_OUT: begin
        a_m = $signed({1'b0, mag40(acc_sel)});
        b_m = $signed({3'b000, gain});
      end
      mtps_pkg::MUL_DAMPR: begin
        a_m = $signed({1'b0, mag40(accr_q[cmd_i.ch])});
        b_m = $signed({4'b0000, fdamp_q});
      end
      mtps_pkg::MUL_DAMPI: begin
        a_m = $signed({1'b0, mag40(acci_q[cmd_i.ch])});
        b_m = $signed({4'b0000, fdamp_q});
      end
      mtps_pkg::MUL_PEAK: begin
        a_m = $signed({9'd0, peak_q});
        b_m = $signed({4'b0000, adamp_q});
      end
      default: begin
        a_m = '0;
        b_m = '0;
      end
    endcase
  end

  assign p_d = a_m * b_m;

  // Restoring divider step, one quotient bit per cycle.
  assign rem2 = {rem_q, lo_q[mtps_pkg::Q_BITS-1]};
  assign ge   = rem2 >= {1'b0, dvs_q};

  // Rounded numerator scaled down by 2^16, so only the frame length remains as divisor.
  assign ysum = p_q[55:0] + {25'd0, spf_eff, 15'd0};
  assign y    = ysum[55:16];

  assign low_mask = (4'b0010 << cmd_i.ch) - 4'b0001;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      spf_q       <= 16'd1;
      fdamp_q     <= '0;
      adamp_q     <= '0;
      peak_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < mtps_pkg::CHANNELS; i++) begin
        inc_q[i]  <= '0;
        pr_q[i]   <= mtps_pkg::PH_ONE;
        pi_q[i]   <= '0;
        accr_q[i] <= '0;
        acci_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        unique case (mtps_pkg::reg_idx_e'(cfg_index_i))
          mtps_pkg::REG_ENABLE: enable_q <= cfg_data_i[0];
          mtps_pkg::REG_SPF:    spf_q    <= cfg_data_i[15:0];
          mtps_pkg::REG_FDAMP:  fdamp_q  <= cfg_data_i[15:0];
          mtps_pkg::REG_ADAMP:  adamp_q  <= cfg_data_i[15:0];
          mtps_pkg::REG_INC0, mtps_pkg::REG_INC1,
          mtps_pkg::REG_INC2, mtps_pkg::REG_INC3: begin
            // A new increment restarts that channel.
            inc_q[cfg_index_i[1:0]]  <= cfg_data_i;
            pr_q[cfg_index_i[1:0]]   <= mtps_pkg::PH_ONE;
            pi_q[cfg_index_i[1:0]]   <= '0;
            accr_q[cfg_index_i[1:0]] <= '0;
            acci_q[cfg_index_i[1:0]] <= '0;
          end
        endcase
      end
      unique case (cmd_i.act)
        mtps_pkg::ACT_PEAK: if (a_pk[31:0] > peak_q) peak_q <= a_pk[31:0];
        mtps_pkg::ACT_NI: begin
          pr_q[cmd_i.ch] <= nr_q;
          pi_q[cmd_i.ch] <= s_rs;
        end
        mtps_pkg::ACT_ACCR: accr_q[cmd_i.ch] <= sat40(41'(accr_q[cmd_i.ch]) + 41'(p_rs));
        mtps_pkg::ACT_ACCI: acci_q[cmd_i.ch] <= sat40(41'(acci_q[cmd_i.ch]) + 41'(p_rs));
        mtps_pkg::ACT_CNT:  cnt_q <= cnt_q + 1'b1;
        mtps_pkg::ACT_DRWR:
          accr_q[cmd_i.ch] <= accr_q[cmd_i.ch][39] ? -damp_pos : damp_pos;
        mtps_pkg::ACT_DIWR:
          acci_q[cmd_i.ch] <= acci_q[cmd_i.ch][39] ? -damp_pos : damp_pos;
        mtps_pkg::ACT_PDAMP: begin
          peak_q <= p_q[47:16];
          cnt_q  <= '0;
        end
        default: ;
      endcase
      if (cmd_i.act == mtps_pkg::ACT_EMIT) out_valid_q <= 1'b1;
      else if (out_ready_i)                out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    unique case (cmd_i.act)
      mtps_pkg::ACT_SMP: smp_q <= sample_i;
      mtps_pkg::ACT_NLOAD: begin
        rem_q <= a_pk[32:1];
        lo_q  <= '0;
        dvs_q <= peak_q;
        quo_q <= '0;
      end
      mtps_pkg::ACT_DIV: begin
        rem_q <= ge ? 32'(rem2 - {1'b0, dvs_q}) : rem2[31:0];
        quo_q <= {quo_q[mtps_pkg::Q_BITS-2:0], ge};
        lo_q  <= {lo_q[mtps_pkg::Q_BITS-2:0], 1'b0};
      end
      mtps_pkg::ACT_NSTORE:
        n_q <= smp_q[mtps_pkg::SAMPLE_BITS-1] ? -$signed({1'b0, quo_q})
                                              : $signed({1'b0, quo_q});
      mtps_pkg::ACT_SLOAD: s_q <= p_q[39:0];
      mtps_pkg::ACT_SSUB:  s_q <= s_q - p_q[39:0];
      mtps_pkg::ACT_NR: begin
        nr_q <= s_rs;
        s_q  <= p_q[39:0];
      end
      mtps_pkg::ACT_SADD: s_q <= s_q + p_q[39:0];
      mtps_pkg::ACT_NI:   ni_q <= s_rs;
      mtps_pkg::ACT_OLOAD: begin
        // A quotient of 2^18 or more saturates whatever the divider returns.
        ovf_q <= y[39:18] >= {6'd0, spf_eff};
        rem_q <= {16'd0, y[33:18]};
        lo_q  <= y[17:0];
        dvs_q <= {16'd0, spf_eff};
        quo_q <= '0;
      end
      mtps_pkg::ACT_OSTORE: begin
        if (cmd_i.im) resi_q <= out_sat(quo_q, ovf_q, acc_sel[39]);
        else          resr_q <= out_sat(quo_q, ovf_q, acc_sel[39]);
      end
      mtps_pkg::ACT_EMIT: begin
        chan_q <= cmd_i.ch;
        outr_q <= resr_q;
        outi_q <= resi_q;
        last_q <= (active & ~low_mask) == '0;
      end
      default: ;
    endcase
  end

  assign sts_o.enable    = enable_q;
  assign sts_o.peak_zero = (peak_q == '0);
  assign sts_o.frame_end = (cnt_q >= spf_eff);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.active    = active;

  assign out_valid_o  = out_valid_q;
  assign channel_o    = chan_q;
  assign phase_real_o = outr_q;
  assign phase_imag_o = outi_q;
  assign last_o       = last_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.act == mtps_pkg::ACT_DIV |-> dvs_q != '0)
    else $error("divider running with a zero divisor");

  a_n_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.act == mtps_pkg::ACT_NSTORE |-> quo_q <= 18'd131072)
    else $error("normalized sample exceeds unity");

  a_nlod_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.act == mtps_pkg::ACT_NLOAD |-> a_pk[31:0] <= peak_q)
    else $error("sample magnitude above peak at normalization");

endmodule

### rtl/core/multi_tone_phasor_stroboscope.sv
// Bank of four quadrature lock-in detectors fed by one audio sample stream.
// Input channel: in_valid_i/in_ready_o with sample_i. Each transaction is one
// signed sample; while disabled, transactions are taken and dropped.
// Output channel: out_valid_o/out_ready_i carrying channel_o, phase_real_o,
// phase_imag_o and last_o; one transaction per active channel at each frame
// end, in channel order, last_o set on the final one.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i,
// always ready; write only while the block is idle.
// Sequencing: each sample passes the bit-serial normalizing divider, then
// the shared multiplier, which serves the active channels one after another.
// At a frame end each result needs two more divisions.
// Results leave through a single output register; a stalled receiver holds
// the sequencer at the next result only, and a new sample is taken as soon
// as the frame work is done even while the last result still waits.
// Reset clears all configuration to defaults (frame length one), all
// phasors to unity, accumulators, peak and frame count to zero.
module multi_tone_phasor_stroboscope (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [mtps_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [mtps_pkg::CH_W-1:0]              channel_o,
  output logic signed [mtps_pkg::PH_W-1:0]       phase_real_o,
  output logic signed [mtps_pkg::PH_W-1:0]       phase_imag_o,
  output logic                                   last_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mtps_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mtps_pkg::INC_W-1:0]             cfg_data_i
);

  mtps_pkg::cmd_t cmd;
  mtps_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  mtps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mtps_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .sample_i     (sample_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .channel_o    (channel_o),
    .phase_real_o (phase_real_o),
    .phase_imag_o (phase_imag_o),
    .last_o       (last_o)
  );

endmodule

### dv/tb_multi_tone_phasor_stroboscope.sv
module tb_multi_tone_phasor_stroboscope;

  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 400;

  typedef struct {
    logic [mtps_pkg::CH_W-1:0]        ch;
    logic signed [mtps_pkg::PH_W-1:0] re;
    logic signed [mtps_pkg::PH_W-1:0] im;
    logic                             last;
  } phase_t;

  logic                                    clk_i;
  logic                                    rst_ni;
  logic                                    in_valid_i;
  logic                                    in_ready_o;
  logic signed [mtps_pkg::SAMPLE_BITS-1:0] sample_i;
  logic                                    out_valid_o;
  logic                                    out_ready_i;
  logic [mtps_pkg::CH_W-1:0]               channel_o;
  logic signed [mtps_pkg::PH_W-1:0]        phase_real_o;
  logic signed [mtps_pkg::PH_W-1:0]        phase_imag_o;
  logic                                    last_o;
  logic                                    cfg_valid_i;
  logic                                    cfg_ready_o;
  logic [mtps_pkg::CFG_IDX_W-1:0]          cfg_index_i;
  logic [mtps_pkg::INC_W-1:0]              cfg_data_i;

  // Predictor copy of configuration and detector state.
  logic                       en_q;
  logic [15:0]                spf_q, fdamp_q, adamp_q;
  logic [mtps_pkg::INC_W-1:0] inc_q [mtps_pkg::CHANNELS];
  longint                     ph_re [mtps_pkg::CHANNELS];
  longint                     ph_im [mtps_pkg::CHANNELS];
  longint                     acc_re [mtps_pkg::CHANNELS];
  longint                     acc_im [mtps_pkg::CHANNELS];
  longint                     peak_q;
  int unsigned                frame_cnt;

  phase_t phase_exp_q[$];
  int     mismatch_cnt;
  int     idle_cycles;
  int     items_sent;
  bit     gaps_on, stalls_on;
  int     stall_left;

  multi_tone_phasor_stroboscope u_dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic longint sat_to(longint v, int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint round_shr(longint v, int sh);
    longint m;
    m = ((v < 0 ? -v : v) + (64'sd1 <<< (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint damp_by(longint v, longint d);
    longint m;
    m = ((v < 0 ? -v : v) * d) >>> 16;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint scale_out(longint v, longint g, longint dv);
    longint m;
    m = ((v < 0 ? -v : v) * g + dv / 2) / dv;
    return sat_to(v < 0 ? -m : m, mtps_pkg::PH_W);
  endfunction

  task automatic clear_channel(int ch);
    ph_re[ch]  = 131071;
    ph_im[ch]  = 0;
    acc_re[ch] = 0;
    acc_im[ch] = 0;
  endtask

  task automatic apply_reg(mtps_pkg::reg_idx_e idx, logic [mtps_pkg::INC_W-1:0] val);
    case (idx)
      mtps_pkg::REG_ENABLE: en_q = val[0];
      mtps_pkg::REG_SPF:    spf_q = val[15:0];
      mtps_pkg::REG_FDAMP:  fdamp_q = val[15:0];
      mtps_pkg::REG_ADAMP:  adamp_q = val[15:0];
      default: begin
        inc_q[int'(idx) - int'(mtps_pkg::REG_INC0)] = val;
        clear_channel(int'(idx) - int'(mtps_pkg::REG_INC0));
      end
    endcase
  endtask

  task automatic predict_sample(logic signed [mtps_pkg::SAMPLE_BITS-1:0] s);
    longint smag, nrm, cr, ci, pr, pi, spf_e, dv, g;
    phase_t frame_q[$];
    phase_t r;
    if (!en_q) return;
    smag = s < 0 ? -longint'(s) : longint'(s);
    if ((smag << 16) > peak_q) peak_q = smag << 16;
    if (peak_q == 0) return;
    nrm = (smag << 33) / peak_q;
    if (s < 0) nrm = -nrm;
    for (int ch = 0; ch < mtps_pkg::CHANNELS; ch++) begin
      if (inc_q[ch] == 0) continue;
      cr = longint'($signed(inc_q[ch][35:18]));
      ci = longint'($signed(inc_q[ch][17:0]));
      pr = ph_re[ch];
      pi = ph_im[ch];
      ph_re[ch] = sat_to(round_shr(pr * cr - pi * ci, 17), mtps_pkg::PH_W);
      ph_im[ch] = sat_to(round_shr(pr * ci + pi * cr, 17), mtps_pkg::PH_W);
      acc_re[ch] = sat_to(acc_re[ch] + round_shr(ph_re[ch] * nrm, 17), mtps_pkg::ACC_W);
      acc_im[ch] = sat_to(acc_im[ch] + round_shr(ph_im[ch] * nrm, 17), mtps_pkg::ACC_W);
    end
    frame_cnt = (frame_cnt + 1) & 16'hFFFF;
    spf_e = spf_q == 0 ? 1 : longint'(spf_q);
    if (frame_cnt < spf_e) return;
    dv = spf_e << 16;
    g = 65536 - longint'(fdamp_q);
    for (int ch = 0; ch < mtps_pkg::CHANNELS; ch++) begin
      if (inc_q[ch] == 0) continue;
      r.ch   = mtps_pkg::CH_W'(ch);
      r.re   = mtps_pkg::PH_W'(scale_out(acc_re[ch], g, dv));
      r.im   = mtps_pkg::PH_W'(scale_out(acc_im[ch], g, dv));
      r.last = 1'b0;
      frame_q.insert(frame_q.size(), r);
    end
    if (frame_q.size() > 0) frame_q[frame_q.size() - 1].last = 1'b1;
    foreach (frame_q[i]) phase_exp_q.insert(phase_exp_q.size(), frame_q[i]);
    for (int ch = 0; ch < mtps_pkg::CHANNELS; ch++) begin
      acc_re[ch] = damp_by(acc_re[ch], fdamp_q);
      acc_im[ch] = damp_by(acc_im[ch], fdamp_q);
    end
    peak_q = (peak_q * longint'(adamp_q)) >> 16;
    frame_cnt = 0;
  endtask

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_sample(logic signed [mtps_pkg::SAMPLE_BITS-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    predict_sample(s);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drops valid, waits for all pending results, then lets the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (phase_exp_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_reg(mtps_pkg::reg_idx_e idx, logic [mtps_pkg::INC_W-1:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    phase_t e;
    if (out_valid_o && out_ready_i) begin
      if (phase_exp_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: ch %0d re %0d im %0d last %0b",
                   channel_o, phase_real_o, phase_imag_o, last_o);
      end else begin
        e = phase_exp_q.pop_front();
        if (e.ch !== channel_o || e.re !== phase_real_o || e.im !== phase_imag_o ||
            e.last !== last_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result mismatch: exp ch %0d re %0d im %0d last %0b, got ch %0d re %0d im %0d last %0b",
                     e.ch, e.re, e.im, e.last,
                     channel_o, phase_real_o, phase_imag_o, last_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    int r;
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!stalls_on) begin
      out_ready_i <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 15) stall_left = (r < 2) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      out_ready_i <= (r >= 15);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_disabled_and_empty();
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    write_reg(mtps_pkg::REG_ENABLE, 1);
    // Peak is still zero, so this sample must be skipped.
    send_sample(0);
    // Frames end with no active channel: no results, only damping.
    send_sample(100);
    send_sample(-5);
  endtask

  task automatic test_directed();
    write_reg(mtps_pkg::REG_INC0, {18'h1FFFF, 18'h00000});
    write_reg(mtps_pkg::REG_INC1, {18'h20000, 18'h20000});
    write_reg(mtps_pkg::REG_INC2, {18'h00000, 18'h1FFFF});
    write_reg(mtps_pkg::REG_INC3, {mtps_pkg::INC_W{1'b1}});
    write_reg(mtps_pkg::REG_ADAMP, 16'hFFFF);
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(0);
    send_sample(1);
    send_sample(-1);
    write_reg(mtps_pkg::REG_FDAMP, 16'hFFFF);
    write_reg(mtps_pkg::REG_SPF, 3);
    repeat (3) send_sample(-16'sh8000);
    write_reg(mtps_pkg::REG_SPF, 0);
    send_sample(16'sh7FFF);
    send_sample(12345);
    // Shorten the frame while samples are already counted.
    write_reg(mtps_pkg::REG_SPF, 16'hFFFF);
    send_sample(-300);
    send_sample(301);
    write_reg(mtps_pkg::REG_SPF, 2);
    send_sample(7);
    // Peak decays to zero at the frame end, then a zero sample is skipped.
    write_reg(mtps_pkg::REG_ADAMP, 0);
    write_reg(mtps_pkg::REG_SPF, 1);
    write_reg(mtps_pkg::REG_FDAMP, 0);
    send_sample(-2);
    send_sample(0);
    send_sample(0);
    write_reg(mtps_pkg::REG_ENABLE, 0);
    send_sample(55);
    write_reg(mtps_pkg::REG_ENABLE, 1);
  endtask

  function automatic logic [15:0] pick_damping();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom());
  endfunction

  task automatic test_random();
    int n, r;
    logic [mtps_pkg::INC_W-1:0] inc;
    while (items_sent < 470) begin
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      write_reg(mtps_pkg::REG_ENABLE, $urandom_range(0, 9) != 0);
      r = $urandom_range(0, 9);
      write_reg(mtps_pkg::REG_SPF,
                r == 0 ? 0 : (r < 8 ? $urandom_range(1, 6) : $urandom_range(7, 40)));
      write_reg(mtps_pkg::REG_FDAMP, pick_damping());
      write_reg(mtps_pkg::REG_ADAMP, pick_damping());
      for (int ch = 0; ch < mtps_pkg::CHANNELS; ch++) begin
        if ($urandom_range(0, 2) == 0) begin
          inc = ($urandom_range(0, 3) == 0) ? '0 : {4'($urandom()), 32'($urandom())};
          write_reg(mtps_pkg::reg_idx_e'(int'(mtps_pkg::REG_INC0) + ch), inc);
        end
      end
      n = $urandom_range(20, 60);
      repeat (n) begin
        r = $urandom_range(0, 19);
        if (r == 0) send_sample(0);
        else if (r == 1) send_sample(-16'sh8000);
        else if (r == 2) send_sample(16'sh7FFF);
        else if (r < 8) send_sample(16'($signed(10'($urandom()))));
        else send_sample(16'($urandom()));
      end
    end
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    sample_i     = '0;
    out_ready_i  = 1'b1;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = mtps_pkg::REG_ENABLE;
    cfg_data_i   = '0;
    en_q         = 1'b0;
    spf_q        = 16'd1;
    fdamp_q      = '0;
    adamp_q      = '0;
    peak_q       = 0;
    frame_cnt    = 0;
    mismatch_cnt = 0;
    idle_cycles  = 0;
    items_sent   = 0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    stall_left   = 0;
    for (int ch = 0; ch < mtps_pkg::CHANNELS; ch++) begin
      inc_q[ch] = '0;
      clear_channel(ch);
    end
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_disabled_and_empty();
    test_directed();
    test_random();
    drain();
    if (mismatch_cnt == 0 && phase_exp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
